[rtl/core/bfve_pkg.sv]
// Package for the bounded float vector engine.
// Holds sizes, operation and status codes, cell control struct and the float compare.
// No dependencies.
`default_nettype none
package bfve_pkg;
   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int POS_W    = 8;

   typedef enum logic [2:0] {
      OP_PUSH_BACK     = 3'd0,
      OP_PUSH_FRONT    = 3'd1,
      OP_INSERT_AT     = 3'd2,
      OP_REMOVE_AT     = 3'd3,
      OP_POP_BACK      = 3'd4,
      OP_POP_FRONT     = 3'd5,
      OP_INSERT_SORTED = 3'd6,
      OP_FIND          = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   // Broadcast to every cell in the chain.
   typedef struct packed {
      logic              ins;
      logic              rem;
      logic [CNT_W-1:0]  idx;
      logic [31:0]       key;
   } cell_ctrl_type;

   // Result of comparing a key against an entry.
   typedef struct packed {
      logic lt;
      logic gt;
   } cmp_type;

   function automatic cmp_type float_cmp(input logic [31:0] a, input logic [31:0] b);
      cmp_type     r;
      logic        nan_a;
      logic        nan_b;
      logic [31:0] ka;
      logic [31:0] kb;
      nan_a = (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
      nan_b = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
      // Map sign-magnitude onto an unsigned order.
      ka = a[31] ? ~a : (a ^ 32'h8000_0000);
      kb = b[31] ? ~b : (b ^ 32'h8000_0000);
      r.lt = 1'b0;
      r.gt = 1'b0;
      if (!(nan_a || nan_b || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)))) begin
         r.lt = ka < kb;
         r.gt = ka > kb;
      end
      return r;
   endfunction
endpackage
`default_nettype wire

[rtl/core/bfve_cell.sv]
// One storage cell of the engine's chain: holds one entry and its compare result.
// Depends on bfve_pkg.
`default_nettype none
module bfve_cell (
   input  wire logic                       clock,
   input  wire bfve_pkg::cell_ctrl_type    ctrl,
   input  wire logic [bfve_pkg::IDX_W-1:0] cell_index,
   input  wire logic [31:0]                left_entry,
   input  wire logic [31:0]                right_entry,
   output logic [31:0]                     entry,
   output bfve_pkg::cmp_type               cmp
);
   logic [31:0]       entry_ff, entry_in;
   bfve_pkg::cmp_type cmp_ff;
   logic [bfve_pkg::CNT_W-1:0] my_idx;

   assign my_idx = bfve_pkg::CNT_W'(cell_index);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (my_idx == ctrl.idx) begin
            entry_in = ctrl.key;
         end else if (my_idx > ctrl.idx) begin
            entry_in = left_entry;
         end
      end else if (ctrl.rem && (my_idx >= ctrl.idx)) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      cmp_ff   <= bfve_pkg::float_cmp(ctrl.key, entry_ff);
   end

   assign entry = entry_ff;
   assign cmp   = cmp_ff;
endmodule
`default_nettype wire

[rtl/core/bounded_float_vector_engine.sv]
// Bounded float vector engine: a chain of entry cells under a search/control sequencer.
// Depends on bfve_pkg and bfve_cell.
//
// Transfer an operation with start while busy is low. Positional operations go from idle
// to the execute state; find and sorted insert pass a compare state, a binary search
// (at most seven steps) and then step over equal entries after a hit. The cells compare
// the key in parallel, the sequencer walks the search one step a cycle, and the whole
// chain shifts at once. The result appears for one cycle with rsp_valid; the receiver
// cannot stall it.
`default_nettype none
module bounded_float_vector_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_func,
   input  wire logic [6:0]  req_position_in,
   input  wire logic [31:0] req_value_in,
   output logic             rsp_valid,
   output logic [31:0]      rsp_value_out,
   output logic signed [7:0] rsp_position_out,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_count
);
   localparam int N  = bfve_pkg::CAPACITY;
   localparam int CW = bfve_pkg::CNT_W;
   localparam int PW = bfve_pkg::POS_W;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_CMP    = 5'b00010,
      S_SEARCH = 5'b00100,
      S_EXTEND = 5'b01000,
      S_EXEC   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0]  op_ff;
   logic [CW-1:0] pos_ff;
   logic [31:0] key_ff;
   logic [CW-1:0] occ_ff, occ_in;
   logic signed [PW-1:0] low_ff, low_in, high_ff, high_in, mid_ff, mid_in;
   logic signed [PW-1:0] res_ff, res_in;
   logic        rsp_valid_ff;
   logic [31:0] rsp_value_ff;
   logic signed [PW-1:0] rsp_pos_ff, rsp_pos_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [CW-1:0] rsp_count_ff;

   bfve_pkg::cell_ctrl_type ctrl;
   logic [31:0] entries [N];
   bfve_pkg::cmp_type cmps [N];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         bfve_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .cell_index  (bfve_pkg::IDX_W'(g)),
            .left_entry  ((g == 0) ? entries[0] : entries[(g == 0) ? 0 : g - 1]),
            .right_entry ((g == N - 1) ? entries[N - 1] : entries[(g == N - 1) ? g : g + 1]),
            .entry       (entries[g]),
            .cmp         (cmps[g])
         );
      end
   endgenerate

   logic signed [PW-1:0] mid_c;
   logic [bfve_pkg::IDX_W-1:0] mid_idx, next_idx;
   logic full;
   logic [CW-1:0] ins_sorted, rem_idx;
   logic [31:0] rem_value;
   logic [PW-1:0] res_plus;

   assign full     = occ_ff >= CW'(N);
   assign mid_c    = (low_ff + high_ff) >>> 1;
   assign mid_idx  = mid_c[bfve_pkg::IDX_W-1:0];
   assign next_idx = mid_ff[bfve_pkg::IDX_W-1:0] + 1'b1;
   assign res_plus = res_ff + 8'sd1;
   assign ins_sorted = res_ff[PW-1] ? CW'(-res_plus) : CW'(res_plus);

   always_comb begin
      unique case (bfve_pkg::op_type'(op_ff))
         bfve_pkg::OP_REMOVE_AT: rem_idx = pos_ff;
         bfve_pkg::OP_POP_BACK:  rem_idx = occ_ff - 1'b1;
         default:                rem_idx = '0;
      endcase
   end

   always_comb begin
      rem_value = '0;
      for (int i = 0; i < N; i++) begin
         if (rem_idx == CW'(i)) begin
            rem_value = rem_value | entries[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      mid_in   = mid_ff;
      res_in   = res_ff;
      occ_in   = occ_ff;
      ctrl.ins = 1'b0;
      ctrl.rem = 1'b0;
      ctrl.idx = '0;
      ctrl.key = key_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if ((req_func == bfve_pkg::OP_FIND) ||
                   (req_func == bfve_pkg::OP_INSERT_SORTED)) begin
                  state_in = S_CMP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_CMP: begin
            low_in   = '0;
            high_in  = PW'(occ_ff) - 8'sd1;
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (low_ff <= high_ff) begin
               if (cmps[mid_idx].lt) begin
                  high_in = mid_c - 8'sd1;
               end else if (cmps[mid_idx].gt) begin
                  low_in = mid_c + 8'sd1;
               end else begin
                  mid_in   = mid_c;
                  state_in = S_EXTEND;
               end
            end else begin
               res_in   = -(low_ff + 8'sd1);
               state_in = S_EXEC;
            end
         end
         S_EXTEND: begin
            if ((mid_ff < high_ff) && !cmps[next_idx].lt && !cmps[next_idx].gt) begin
               mid_in = mid_ff + 8'sd1;
            end else begin
               res_in   = mid_ff;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            unique case (bfve_pkg::op_type'(op_ff))
               bfve_pkg::OP_PUSH_BACK: begin
                  ctrl.ins = !full;
                  ctrl.idx = occ_ff;
               end
               bfve_pkg::OP_PUSH_FRONT: ctrl.ins = !full;
               bfve_pkg::OP_INSERT_AT: begin
                  ctrl.ins = !full && (pos_ff <= occ_ff);
                  ctrl.idx = pos_ff;
               end
               bfve_pkg::OP_INSERT_SORTED: begin
                  ctrl.ins = !full;
                  ctrl.idx = ins_sorted;
               end
               bfve_pkg::OP_REMOVE_AT: begin
                  ctrl.rem = pos_ff < occ_ff;
                  ctrl.idx = rem_idx;
               end
               bfve_pkg::OP_POP_BACK, bfve_pkg::OP_POP_FRONT: begin
                  ctrl.rem = occ_ff != '0;
                  ctrl.idx = rem_idx;
               end
               default: ;
            endcase
            if (ctrl.ins) begin
               occ_in = occ_ff + 1'b1;
            end else if (ctrl.rem) begin
               occ_in = occ_ff - 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_pos_in    = '0;
      rsp_status_in = bfve_pkg::ST_OK;
      unique case (bfve_pkg::op_type'(op_ff))
         bfve_pkg::OP_FIND: rsp_pos_in = res_ff;
         bfve_pkg::OP_INSERT_SORTED: begin
            rsp_pos_in = PW'(ins_sorted);
            if (full) rsp_status_in = bfve_pkg::ST_FULL;
         end
         bfve_pkg::OP_PUSH_BACK, bfve_pkg::OP_PUSH_FRONT: begin
            if (full) rsp_status_in = bfve_pkg::ST_FULL;
         end
         bfve_pkg::OP_INSERT_AT: begin
            if (pos_ff > occ_ff) rsp_status_in = bfve_pkg::ST_BAD;
            else if (full) rsp_status_in = bfve_pkg::ST_FULL;
         end
         bfve_pkg::OP_REMOVE_AT: begin
            if (pos_ff >= occ_ff) rsp_status_in = bfve_pkg::ST_BAD;
         end
         bfve_pkg::OP_POP_BACK, bfve_pkg::OP_POP_FRONT: begin
            if (occ_ff == '0) rsp_status_in = bfve_pkg::ST_BAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= state_ff == S_EXEC;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      high_ff <= high_in;
      mid_ff  <= mid_in;
      res_ff  <= res_in;
      if (state_ff == S_IDLE) begin
         op_ff  <= req_func;
         pos_ff <= req_position_in;
         key_ff <= req_value_in;
      end
      if (state_ff == S_EXEC) begin
         rsp_value_ff  <= ctrl.rem ? rem_value : 32'd0;
         rsp_count_ff  <= occ_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_out    = rsp_value_ff;
   assign rsp_position_out = rsp_pos_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = rsp_count_ff;
endmodule
`default_nettype wire

[rtl/core/bfve_checker.sv]
// Port-level checker for the bounded float vector engine, bound to the top level.
// Depends on bfve_pkg and bounded_float_vector_engine.
`default_nettype none
module bfve_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [1:0] rsp_status,
   input wire logic [6:0] rsp_count
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted transfer did not raise busy");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held two cycles");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3) else $error("undefined status code");
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bfve_pkg::ST_FULL) |-> rsp_count == 7'(bfve_pkg::CAPACITY))
      else $error("full status with store not full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= 7'(bfve_pkg::CAPACITY)) else $error("count above capacity");
endmodule

bind bounded_float_vector_engine bfve_checker u_bfve_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status),
   .rsp_count  (rsp_count)
);
`default_nettype wire

[verif/tb_top.sv]
// Self-checking testbench for the bounded float vector engine.
// Drives operations through start/busy and checks every rsp_valid result against a predictor.
// Depends on bfve_pkg and bounded_float_vector_engine.
`timescale 1ns / 1ps
module tb_top;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [31:0] value_out;
      logic [7:0]  position_out;
      logic [1:0]  status;
      logic [6:0]  count;
   } vec_result_type;

   typedef struct {
      bfve_pkg::op_type func;
      logic [6:0]       position;
      logic [31:0]      value;
      logic             typed;
      vec_result_type   want;
   } vec_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_func;
   logic [6:0]  req_position_in;
   logic [31:0] req_value_in;
   logic        rsp_valid;
   logic [31:0] rsp_value_out;
   logic signed [7:0] rsp_position_out;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_count;

   logic [31:0] model_entries [bfve_pkg::CAPACITY];
   int unsigned model_fill;
   vec_result_type pending_results [$];
   int unsigned error_count;
   int unsigned idle_cycles;
   int unsigned ops_sent;
   int unsigned results_seen;
   int unsigned full_hits;
   int unsigned bad_hits;
   vec_row_type directed_rows [$];

   bounded_float_vector_engine uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_position_in(req_position_in),
      .req_value_in(req_value_in), .rsp_valid(rsp_valid),
      .rsp_value_out(rsp_value_out), .rsp_position_out(rsp_position_out),
      .rsp_status(rsp_status), .rsp_count(rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // IEEE value order: -1 less, 1 greater, 0 equal; NaN and signed zeros are equal.
   function automatic int float_order(logic [31:0] a, logic [31:0] b);
      logic [31:0] ka;
      logic [31:0] kb;
      if ((a[30:23] == 8'hff && a[22:0] != 23'd0) || (b[30:23] == 8'hff && b[22:0] != 23'd0))
         return 0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
         return 0;
      ka = a[31] ? ~a : {1'b0, a[30:0]} | 32'h8000_0000;
      kb = b[31] ? ~b : {1'b0, b[30:0]} | 32'h8000_0000;
      return (ka < kb) ? -1 : ((ka > kb) ? 1 : 0);
   endfunction

   function automatic int binary_locate(logic [31:0] key);
      int lo;
      int hi;
      int mid;
      int c;
      lo = 0;
      hi = int'(model_fill) - 1;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         c = float_order(key, model_entries[mid]);
         if (c == 0) begin
            while (mid < hi && float_order(key, model_entries[mid + 1]) == 0)
               mid++;
            return mid;
         end
         if (c < 0) hi = mid - 1;
         else lo = mid + 1;
      end
      return -(lo + 1);
   endfunction

   task automatic shift_in(int unsigned idx, logic [31:0] v);
      for (int unsigned i = model_fill; i > idx; i--)
         model_entries[i] = model_entries[i - 1];
      model_entries[idx] = v;
      model_fill++;
   endtask

   task automatic shift_out(int unsigned idx, output logic [31:0] v);
      v = model_entries[idx];
      for (int unsigned i = idx; i + 1 < model_fill; i++)
         model_entries[i] = model_entries[i + 1];
      model_fill--;
   endtask

   task automatic predict_vector_op(bfve_pkg::op_type f, logic [6:0] pos, logic [31:0] val,
                                    output vec_result_type r);
      logic full;
      int   hit;
      int   ins;
      full = model_fill >= bfve_pkg::CAPACITY;
      r.value_out = '0;
      r.position_out = '0;
      r.status = bfve_pkg::ST_OK;
      case (f)
         bfve_pkg::OP_PUSH_BACK: begin
            if (full) r.status = bfve_pkg::ST_FULL; else shift_in(model_fill, val);
         end
         bfve_pkg::OP_PUSH_FRONT: begin
            if (full) r.status = bfve_pkg::ST_FULL; else shift_in(0, val);
         end
         bfve_pkg::OP_INSERT_AT: begin
            if (pos > model_fill) r.status = bfve_pkg::ST_BAD;
            else if (full) r.status = bfve_pkg::ST_FULL;
            else shift_in(int'(pos), val);
         end
         bfve_pkg::OP_REMOVE_AT: begin
            if (pos >= model_fill) r.status = bfve_pkg::ST_BAD;
            else shift_out(int'(pos), r.value_out);
         end
         bfve_pkg::OP_POP_BACK: begin
            if (model_fill == 0) r.status = bfve_pkg::ST_BAD;
            else shift_out(model_fill - 1, r.value_out);
         end
         bfve_pkg::OP_POP_FRONT: begin
            if (model_fill == 0) r.status = bfve_pkg::ST_BAD; else shift_out(0, r.value_out);
         end
         bfve_pkg::OP_INSERT_SORTED: begin
            hit = binary_locate(val);
            ins = (hit >= 0) ? hit + 1 : -(hit + 1);
            r.position_out = ins[7:0];
            if (full) r.status = bfve_pkg::ST_FULL; else shift_in(ins, val);
         end
         default: begin
            hit = binary_locate(val);
            r.position_out = hit[7:0];
         end
      endcase
      r.count = model_fill[6:0];
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Random gap before the next transfer: usually none or short, now and then long.
   task automatic idle_gap();
      int unsigned n;
      n = $urandom_range(0, 9);
      if (n < 5) n = 0;
      else if (n < 9) n = $urandom_range(1, 3);
      else n = $urandom_range(8, 30);
      repeat (n) @(negedge clock);
   endtask

   // Drives one operation and returns once it has been taken.
   task automatic send_op(bfve_pkg::op_type f, logic [6:0] pos, logic [31:0] val,
                          logic typed, vec_result_type want);
      vec_result_type r;
      predict_vector_op(f, pos, val, r);
      if (typed && r != want)
         report_mismatch("directed table vs predictor", {30'd0, r.status}, {30'd0, want.status});
      pending_results.push_back(r);
      req_func = f;
      req_position_in = pos;
      req_value_in = val;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start = 1'b0;
      req_func = 3'($urandom());
      req_position_in = 7'($urandom());
      req_value_in = $urandom();
      ops_sent++;
      if (r.status == bfve_pkg::ST_FULL) full_hits++;
      if (r.status == bfve_pkg::ST_BAD) bad_hits++;
   endtask

   function automatic logic [31:0] pick_float();
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0: v = {1'($urandom_range(0, 1)), 8'hff, 23'd0};
         1: v = {1'($urandom_range(0, 1)), 8'hff, 23'($urandom_range(1, 32'h7f_ffff))};
         2: v = {1'($urandom_range(0, 1)), 31'd0};
         3: v = {1'($urandom_range(0, 1)), 8'd0, 23'($urandom())};
         4: v = $urandom();
         default: v = {1'($urandom_range(0, 1)), 8'($urandom_range(124, 131)),
                       2'($urandom_range(0, 3)), 21'd0};
      endcase
      return v;
   endfunction

   function automatic vec_row_type mk_row(bfve_pkg::op_type f, logic [6:0] p, logic [31:0] v,
                                          logic t, logic [31:0] wv, logic [7:0] wp,
                                          logic [1:0] ws, logic [6:0] wc);
      vec_row_type row;
      row.func = f; row.position = p; row.value = v; row.typed = t;
      row.want.value_out = wv; row.want.position_out = wp;
      row.want.status = ws; row.want.count = wc;
      return row;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_value_out, 32'h0);
            end else begin
               vec_result_type want;
               want = pending_results.pop_front();
               if (rsp_value_out !== want.value_out)
                  report_mismatch("value_out", rsp_value_out, want.value_out);
               if (rsp_position_out !== want.position_out)
                  report_mismatch("position_out", {24'd0, rsp_position_out},
                                  {24'd0, want.position_out});
               if (rsp_status !== want.status)
                  report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
               if (rsp_count !== want.count)
                  report_mismatch("count", {25'd0, rsp_count}, {25'd0, want.count});
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int unsigned target;
      int unsigned kind;
      logic [31:0] v;
      vec_result_type none;
      none = '0;
      error_count = 0; idle_cycles = 0; ops_sent = 0; results_seen = 0;
      full_hits = 0; bad_hits = 0; model_fill = 0;
      start = 1'b0; req_func = '0; req_position_in = '0; req_value_in = '0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty store errors first, then each operation and field extreme.
      directed_rows.push_back(mk_row(bfve_pkg::OP_POP_BACK, 7'd0, 32'h3f80_0000, 1'b1,
                                     32'd0, 8'd0, bfve_pkg::ST_BAD, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_POP_FRONT, 7'd0, 32'h0, 1'b1,
                                     32'd0, 8'd0, bfve_pkg::ST_BAD, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_REMOVE_AT, 7'd0, 32'h0, 1'b1,
                                     32'd0, 8'd0, bfve_pkg::ST_BAD, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_INSERT_AT, 7'h7f, 32'h1, 1'b1,
                                     32'd0, 8'd0, bfve_pkg::ST_BAD, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_FIND, 7'd0, 32'h3f80_0000, 1'b1,
                                     32'd0, 8'hff, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_INSERT_SORTED, 7'd0, 32'h3f80_0000, 1'b1,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd1));
      directed_rows.push_back(mk_row(bfve_pkg::OP_PUSH_BACK, 7'd0, 32'hffff_ffff, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_PUSH_FRONT, 7'd0, 32'h0, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_INSERT_AT, 7'd3, 32'h7f80_0000, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_INSERT_AT, 7'd1, 32'h8000_0000, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_FIND, 7'd0, 32'h7fc0_0000, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_INSERT_SORTED, 7'd0, 32'hff80_0000, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_REMOVE_AT, 7'h7f, 32'h0, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_REMOVE_AT, 7'd2, 32'h0, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_POP_BACK, 7'd0, 32'h0, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      directed_rows.push_back(mk_row(bfve_pkg::OP_POP_FRONT, 7'd0, 32'h0, 1'b0,
                                     32'd0, 8'd0, bfve_pkg::ST_OK, 7'd0));
      foreach (directed_rows[i]) begin
         idle_gap();
         send_op(directed_rows[i].func, directed_rows[i].position, directed_rows[i].value,
                 directed_rows[i].typed, directed_rows[i].want);
      end

      // Fill to capacity and overflow with every insert kind, then drain.
      while (model_fill < bfve_pkg::CAPACITY)
         send_op(bfve_pkg::OP_INSERT_SORTED, 7'($urandom()), pick_float(), 1'b0, none);
      send_op(bfve_pkg::OP_PUSH_BACK, 7'd0, 32'h1, 1'b0, none);
      send_op(bfve_pkg::OP_PUSH_FRONT, 7'd0, 32'h1, 1'b0, none);
      send_op(bfve_pkg::OP_INSERT_AT, 7'd64, 32'h1, 1'b0, none);
      send_op(bfve_pkg::OP_INSERT_AT, 7'd65, 32'h1, 1'b0, none);
      send_op(bfve_pkg::OP_INSERT_SORTED, 7'd0, 32'h1, 1'b0, none);
      send_op(bfve_pkg::OP_FIND, 7'd0, model_entries[10], 1'b0, none);
      send_op(bfve_pkg::OP_REMOVE_AT, 7'd63, 32'h0, 1'b0, none);
      send_op(bfve_pkg::OP_REMOVE_AT, 7'd64, 32'h0, 1'b0, none);
      while (model_fill > 0)
         send_op(bfve_pkg::op_type'($urandom_range(4, 5)), 7'd0, 32'h0, 1'b0, none);

      // Random part: mostly sorted inserts and finds, with positional traffic mixed in.
      target = ops_sent + 550;
      while (ops_sent < target) begin
         idle_gap();
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            send_op(bfve_pkg::OP_INSERT_SORTED, 7'($urandom()), pick_float(), 1'b0, none);
         end else if (kind < 55) begin
            v = (model_fill > 0 && $urandom_range(0, 1)) ?
                model_entries[$urandom_range(0, model_fill - 1)] : pick_float();
            send_op(bfve_pkg::OP_FIND, 7'($urandom()), v, 1'b0, none);
         end else if (kind < 85) begin
            send_op(bfve_pkg::op_type'($urandom_range(3, 5)),
                    7'($urandom_range(0, model_fill + 1)), $urandom(), 1'b0, none);
         end else begin
            send_op(bfve_pkg::op_type'($urandom_range(0, 2)),
                    $urandom_range(0, 1) ? 7'($urandom_range(0, model_fill + 1))
                                         : 7'($urandom()),
                    pick_float(), 1'b0, none);
         end
      end

      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("ran %0d operations, %0d results checked", ops_sent, results_seen);
      $display("full drops %0d, bad index or empty %0d", full_hits, bad_hits);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
